// ===== sv/spbb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spbb_pkg: shared types and constants
// Widths, command and register codes, divider request/status structs.
// ----------------------------------------------------------------------------
package spbb_pkg;

    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int PIDX_W     = 4;
    localparam int STRAIN_W   = 31;
    localparam int STRESS_W   = 32;
    localparam int X_W        = 32;
    localparam int TAN_W      = 48;
    localparam int PC_W       = 5;
    localparam int FS_W       = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;
    localparam int RAM_W      = STRAIN_W + STRESS_W;
    localparam int PROD_W     = STRAIN_W + STRESS_W;

    localparam int DIV_REM_W  = 31;
    localparam int DIV_NUM_W  = 47;
    localparam int DIV_CNT_W  = 6;

    localparam logic [DIV_CNT_W-1:0] SLOPE_STEPS  = 6'd47;
    localparam logic [DIV_CNT_W-1:0] INTERP_STEPS = 6'd32;

    localparam logic signed [TAN_W-1:0] T48_MAX = {1'b0, {(TAN_W-1){1'b1}}};
    localparam logic signed [TAN_W-1:0] T48_MIN = {1'b1, {(TAN_W-1){1'b0}}};
    localparam logic signed [STRESS_W-1:0] S32_MAX = {1'b0, {(STRESS_W-1){1'b1}}};
    localparam logic signed [STRESS_W-1:0] S32_MIN = {1'b1, {(STRESS_W-1){1'b0}}};

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_SHIFT = 1'd1;

    localparam logic [PC_W-1:0] POINT_COUNT_RST = 5'd2;
    localparam logic [FS_W-1:0] FLOOR_SHIFT_RST = 6'd30;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
        logic [DIV_REM_W-1:0] rem_init;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_REM_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } div_stat_t;

endpackage

// ===== sv/spbb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spbb_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module spbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/spbb_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spbb_div: iterative restoring divider
// One quotient bit per cycle; remainder is preloaded, dividend bits shift in.
// ----------------------------------------------------------------------------
module spbb_div (
    input  logic                clk,
    input  logic                rst_n,
    input  spbb_pkg::div_req_t  req,
    output spbb_pkg::div_stat_t stat
);
    import spbb_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_REM_W-1:0] rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [DIV_NUM_W-1:0] quot_reg, quot_next;
    logic [DIV_REM_W-1:0] dvs_reg, dvs_next;

    logic [DIV_REM_W:0] trial;
    logic [DIV_REM_W:0] diff;
    logic               ge;

    assign trial = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        quot_next = quot_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            rem_next  = req.rem_init;
            num_next  = req.num;
            quot_next = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[DIV_REM_W-1:0] : trial[DIV_REM_W-1:0];
            num_next  = {num_reg[DIV_NUM_W-2:0], 1'b0};
            quot_next = {quot_reg[DIV_NUM_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.quot = quot_reg;

endmodule

// ===== sv/symmetric_piecewise_linear_backbone.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symmetric_piecewise_linear_backbone: mirrored piecewise-linear curve
// Point table in RAM, linear search, shared bit-serial divider for interpolation and slopes.
// ----------------------------------------------------------------------------
// Load transfer: writes one table point, no result.
// Evaluate: a linear search reads and compares table points in turn; inside the
//   table the interpolation and segment slope follow; last comes the initial
//   slope from points 0 and 1, on the shared divider where a division is needed.
// One item at a time; a waiting result does not block the next input transfer.
// Reset: point_count 2, floor_shift 30; table contents undefined until loaded.
module symmetric_piecewise_linear_backbone (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  cmd,
    input  logic [spbb_pkg::PIDX_W-1:0]           point_index,
    input  logic [spbb_pkg::STRAIN_W-1:0]         point_strain,
    input  logic signed [spbb_pkg::STRESS_W-1:0]  point_stress,
    input  logic signed [spbb_pkg::X_W-1:0]       strain_in,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [spbb_pkg::STRESS_W-1:0]  stress_out,
    output logic signed [spbb_pkg::TAN_W-1:0]     tangent_out,
    output logic [spbb_pkg::CNT_W-1:0]            segment,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [spbb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [spbb_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import spbb_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SRCH   = 4'd1;
    localparam logic [3:0] S_SCMP   = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_IDIV   = 4'd4;
    localparam logic [3:0] S_IDIV_W = 4'd5;
    localparam logic [3:0] S_SLP    = 4'd6;
    localparam logic [3:0] S_SLP_W  = 4'd7;
    localparam logic [3:0] S_RD0    = 4'd8;
    localparam logic [3:0] S_RD1    = 4'd9;
    localparam logic [3:0] S_RD2    = 4'd10;
    localparam logic [3:0] S_FIN    = 4'd11;

    function automatic logic signed [STRESS_W-1:0] apply_sign(
        input logic signed [STRESS_W-1:0] v,
        input logic                       neg
    );
        logic signed [STRESS_W-1:0] r;
        if (!neg)
        begin
            r = v;
        end
        else if (v == S32_MIN)
        begin
            r = S32_MAX;
        end
        else
        begin
            r = -v;
        end
        return r;
    endfunction

    logic [3:0]                 state_reg, state_next;
    logic [PC_W-1:0]            point_count_reg;
    logic [FS_W-1:0]            floor_shift_reg;
    logic [CNT_W-1:0]           n_reg, n_next;
    logic [CNT_W-1:0]           i_reg, i_next;
    logic [X_W-1:0]             mag_reg, mag_next;
    logic                       xneg_reg, xneg_next;
    logic                       init_phase_reg, init_phase_next;
    logic [STRAIN_W-1:0]        pe_reg, pe_next, ce_reg, ce_next;
    logic signed [STRESS_W-1:0] ps_reg, ps_next, cs_reg, cs_next;
    logic [PROD_W-1:0]          prod_reg, prod_next;
    logic signed [STRESS_W-1:0] stress_reg, stress_next;
    logic signed [TAN_W-1:0]    init_reg, init_next, seg_reg, seg_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [STRESS_W-1:0] stress_out_reg, stress_out_next;
    logic signed [TAN_W-1:0]    tangent_out_reg, tangent_out_next;
    logic [CNT_W-1:0]           segment_reg, segment_next;

    logic                       in_fire;
    logic                       ram_we;
    logic [IDX_W-1:0]           ram_raddr;
    logic [RAM_W-1:0]           ram_rdata;
    logic [STRAIN_W-1:0]        rd_strain;
    logic signed [STRESS_W-1:0] rd_stress;

    div_req_t                   div_req;
    div_stat_t                  div_stat;

    logic signed [STRESS_W:0]   ds_w;
    logic signed [X_W-1:0]      de_w;
    logic [STRESS_W:0]          ds_mag;
    logic [X_W-1:0]             de_abs;
    logic [DIV_REM_W-1:0]       de_mag;
    logic [13:0]                ds_hi;
    logic                       slope_neg;
    logic                       sat_hit;
    logic signed [TAN_W-1:0]    q_slope;
    logic signed [TAN_W-1:0]    slope_res;
    logic [X_W-1:0]             dx;
    logic [PROD_W-1:0]          prod_w;
    logic signed [STRESS_W+1:0] interp_v;

    logic signed [TAN_W-1:0]    fl;
    logic signed [TAN_W-1:0]    tan_sel;
    logic signed [TAN_W-1:0]    tan_t0;
    logic signed [TAN_W-1:0]    neg_fl;
    logic signed [TAN_W-1:0]    tan_fin;

    logic                       slope_wr;
    logic signed [TAN_W-1:0]    slope_val;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign ram_we = in_fire && (cmd == CMD_LOAD) && (int'(point_index) < MAX_POINTS);

    always_comb
    begin
        unique case (state_reg)
            S_SRCH:  ram_raddr = i_reg[IDX_W-1:0];
            S_RD1:   ram_raddr = IDX_W'(1);
            default: ram_raddr = '0;
        endcase
    end

    spbb_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (IDX_W'(point_index)),
        .wdata ({point_strain, point_stress}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_strain = ram_rdata[RAM_W-1:STRESS_W];
    assign rd_stress = ram_rdata[STRESS_W-1:0];

    spbb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    // segment deltas between the two held points
    assign ds_w      = {cs_reg[STRESS_W-1], cs_reg} - {ps_reg[STRESS_W-1], ps_reg};
    assign de_w      = {1'b0, ce_reg} - {1'b0, pe_reg};
    assign ds_mag    = ds_w[STRESS_W] ? $unsigned(-ds_w) : $unsigned(ds_w);
    assign de_abs    = de_w[X_W-1] ? $unsigned(-de_w) : $unsigned(de_w);
    assign de_mag    = de_abs[DIV_REM_W-1:0];
    assign ds_hi     = ds_mag[STRESS_W:19];
    assign slope_neg = ds_w[STRESS_W] ^ de_w[X_W-1];
    assign sat_hit   = ({17'd0, ds_hi} >= de_mag);
    assign q_slope   = {1'b0, div_stat.quot};
    assign slope_res = slope_neg ? -q_slope : q_slope;

    assign dx       = mag_reg - {1'b0, pe_reg};
    assign prod_w   = dx[STRAIN_W-1:0] * ds_mag[STRESS_W-1:0];
    assign interp_v = ds_w[STRESS_W]
                    ? ({{2{ps_reg[STRESS_W-1]}}, ps_reg} - {2'b00, div_stat.quot[31:0]})
                    : ({{2{ps_reg[STRESS_W-1]}}, ps_reg} + {2'b00, div_stat.quot[31:0]});

    // tangent floor handling
    assign fl = init_reg >>> floor_shift_reg;

    always_comb
    begin
        priority if (i_reg == '0)
        begin
            tan_sel = init_reg;
        end
        else if (i_reg == n_reg)
        begin
            tan_sel = '0;
        end
        else
        begin
            tan_sel = seg_reg;
        end
    end

    assign tan_t0  = (tan_sel == '0) ? fl : tan_sel;
    assign neg_fl  = (fl == T48_MIN) ? T48_MAX : -fl;
    assign tan_fin = tan_t0[TAN_W-1] ? neg_fl : tan_t0;

    always_comb
    begin
        state_next       = state_reg;
        n_next           = n_reg;
        i_next           = i_reg;
        mag_next         = mag_reg;
        xneg_next        = xneg_reg;
        init_phase_next  = init_phase_reg;
        pe_next          = pe_reg;
        ps_next          = ps_reg;
        ce_next          = ce_reg;
        cs_next          = cs_reg;
        prod_next        = prod_reg;
        stress_next      = stress_reg;
        init_next        = init_reg;
        seg_next         = seg_reg;
        stress_out_next  = stress_out_reg;
        tangent_out_next = tangent_out_reg;
        segment_next     = segment_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        div_req          = '0;
        slope_wr         = 1'b0;
        slope_val        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (cmd == CMD_EVAL))
                begin
                    if (point_count_reg < PC_W'(2))
                    begin
                        n_next = CNT_W'(2);
                    end
                    else if (int'(point_count_reg) > MAX_POINTS)
                    begin
                        n_next = CNT_W'(MAX_POINTS);
                    end
                    else
                    begin
                        n_next = CNT_W'(point_count_reg);
                    end
                    mag_next        = strain_in[X_W-1] ? $unsigned(-strain_in)
                                                       : $unsigned(strain_in);
                    xneg_next       = strain_in[X_W-1];
                    i_next          = '0;
                    init_phase_next = 1'b0;
                    state_next      = S_SRCH;
                end
            end
            S_SRCH:
            begin
                if (i_reg == n_reg)
                begin
                    stress_next = apply_sign(ps_reg, xneg_reg);
                    state_next  = S_RD0;
                end
                else
                begin
                    state_next = S_SCMP;
                end
            end
            S_SCMP:
            begin
                if (mag_reg > {1'b0, rd_strain})
                begin
                    pe_next    = rd_strain;
                    ps_next    = rd_stress;
                    i_next     = i_reg + 1'b1;
                    state_next = S_SRCH;
                end
                else
                begin
                    ce_next = rd_strain;
                    cs_next = rd_stress;
                    if (i_reg == '0)
                    begin
                        stress_next = '0;
                        state_next  = S_RD0;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                prod_next  = prod_w;
                state_next = S_IDIV;
            end
            S_IDIV:
            begin
                div_req.start    = 1'b1;
                div_req.steps    = INTERP_STEPS;
                div_req.rem_init = prod_reg[PROD_W-1:32];
                div_req.num      = {prod_reg[31:0], 15'd0};
                div_req.divisor  = de_mag;
                state_next       = S_IDIV_W;
            end
            S_IDIV_W:
            begin
                if (div_stat.done)
                begin
                    stress_next = apply_sign(interp_v[STRESS_W-1:0], xneg_reg);
                    state_next  = S_SLP;
                end
            end
            S_SLP:
            begin
                if (ds_w == '0)
                begin
                    slope_wr  = 1'b1;
                    slope_val = '0;
                end
                else if (de_mag == '0)
                begin
                    slope_wr  = 1'b1;
                    slope_val = ds_w[STRESS_W] ? T48_MIN : T48_MAX;
                end
                else if (sat_hit)
                begin
                    slope_wr  = 1'b1;
                    slope_val = slope_neg ? T48_MIN : T48_MAX;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.steps    = SLOPE_STEPS;
                    div_req.rem_init = {17'd0, ds_hi};
                    div_req.num      = {ds_mag[18:0], 28'd0};
                    div_req.divisor  = de_mag;
                    state_next       = S_SLP_W;
                end
                if (slope_wr)
                begin
                    state_next = init_phase_reg ? S_FIN : S_RD0;
                end
            end
            S_SLP_W:
            begin
                if (div_stat.done)
                begin
                    slope_wr   = 1'b1;
                    slope_val  = slope_res;
                    state_next = init_phase_reg ? S_FIN : S_RD0;
                end
            end
            S_RD0:
            begin
                state_next = S_RD1;
            end
            S_RD1:
            begin
                pe_next    = rd_strain;
                ps_next    = rd_stress;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                ce_next         = rd_strain;
                cs_next         = rd_stress;
                init_phase_next = 1'b1;
                state_next      = S_SLP;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    stress_out_next  = stress_reg;
                    tangent_out_next = tan_fin;
                    segment_next     = i_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (slope_wr)
        begin
            if (init_phase_reg)
            begin
                init_next = slope_val;
            end
            else
            begin
                seg_next = slope_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            point_count_reg <= POINT_COUNT_RST;
            floor_shift_reg <= FLOOR_SHIFT_RST;
            n_reg           <= CNT_W'(2);
            i_reg           <= '0;
            init_phase_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            n_reg          <= n_next;
            i_reg          <= i_next;
            init_phase_reg <= init_phase_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_POINT_COUNT)
                begin
                    point_count_reg <= cfg_data[PC_W-1:0];
                end
                else if (cfg_index == CFG_FLOOR_SHIFT)
                begin
                    floor_shift_reg <= cfg_data[FS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg         <= mag_next;
        xneg_reg        <= xneg_next;
        pe_reg          <= pe_next;
        ps_reg          <= ps_next;
        ce_reg          <= ce_next;
        cs_reg          <= cs_next;
        prod_reg        <= prod_next;
        stress_reg      <= stress_next;
        init_reg        <= init_next;
        seg_reg         <= seg_next;
        stress_out_reg  <= stress_out_next;
        tangent_out_reg <= tangent_out_next;
        segment_reg     <= segment_next;
    end

    assign out_valid   = out_valid_reg;
    assign stress_out  = stress_out_reg;
    assign tangent_out = tangent_out_reg;
    assign segment     = segment_reg;

    a_eval_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (cmd == CMD_EVAL)) |=> (state_reg == S_SRCH))
        else $error("evaluate transfer did not start the search");

    a_search_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCMP) |-> (i_reg < n_reg))
        else $error("search compared past the points in use");

    a_div_running: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_IDIV_W) || (state_reg == S_SLP_W))
            |-> (div_stat.busy || div_stat.done))
        else $error("waiting on a divider that is not running");

    a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FIN) && (!out_valid_reg || out_ready))
            |=> (out_valid_reg && (state_reg == S_IDLE)))
        else $error("finished result not placed in output register");

endmodule

// ===== sim/symmetric_piecewise_linear_backbone_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symmetric_piecewise_linear_backbone_test: self-checking bench for the backbone
// Loads point tables, evaluates signed strains and checks stress, tangent and
// segment against fixed probe values and an in-bench curve predictor, under several register
// settings and idle/stall patterns on both streams.
// ----------------------------------------------------------------------------
module symmetric_piecewise_linear_backbone_test;
    import spbb_pkg::*;

    typedef struct packed {
        logic signed [STRESS_W-1:0] stress;
        logic signed [TAN_W-1:0]    tangent;
        logic [CNT_W-1:0]           seg;
    } backbone_result_t;

    typedef struct packed {
        logic                       op;
        logic [PIDX_W-1:0]          slot;
        logic [STRAIN_W-1:0]        strain;
        logic signed [STRESS_W-1:0] stress;
        logic signed [X_W-1:0]      x;
        logic                       known;
        backbone_result_t           want;
    } probe_t;

    localparam backbone_result_t NO_RESULT = '0;
    localparam longint TAN_HI = T48_MAX;
    localparam longint TAN_LO = T48_MIN;
    localparam longint S_HI = S32_MAX;
    localparam longint S_LO = S32_MIN;
    localparam longint STRAIN_TOP = 64'sd2147483647;
    localparam int QUIET_CYCLES = 200;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 235;

    localparam logic [CFG_DATA_W-1:0] PC_SET [PHASES] =
        '{6'd16, 6'd2, 6'd3, 6'd63, 6'd0, 6'd17, 6'd36, 6'd0};
    localparam logic [CFG_DATA_W-1:0] FS_SET [PHASES] =
        '{6'd0, 6'd47, 6'd30, 6'd63, 6'd1, 6'd0, 6'd15, 6'd0};

    localparam probe_t PROBES [24] = '{
        '{CMD_LOAD, 4'd0, 31'h1000_0000, 32'sh0000_0100, 32'sh0, 1'b0, NO_RESULT},
        '{CMD_LOAD, 4'd1, 31'h2000_0000, 32'sh0000_0200, 32'sh0, 1'b0, NO_RESULT},
        '{CMD_EVAL, 4'd0, 31'h0, 32'sh0, 32'sh0000_0000, 1'b1,
          '{32'sh0, 48'sh0000_0000_0100, 5'd0}},
        '{CMD_EVAL, 4'd0, 31'h0, 32'sh0, 32'sh1000_0000, 1'b1,
          '{32'sh0, 48'sh0000_0000_0100, 5'd0}},
        '{CMD_EVAL, 4'd0, 31'h0, 32'sh0, 32'sh1800_0000, 1'b1,
          '{32'sh0000_0180, 48'sh0000_0000_0100, 5'd1}},
        '{CMD_EVAL, 4'd0, 31'h0, 32'sh0, 32'shE800_0000, 1'b1,
          '{32'shFFFF_FE80, 48'sh0000_0000_0100, 5'd1}},
        '{CMD_EVAL, 4'd0, 31'h0, 32'sh0, 32'sh2000_0000, 1'b1,
          '{32'sh0000_0200, 48'sh0000_0000_0100, 5'd1}},
        '{CMD_EVAL, 4'd0, 31'h0, 32'sh0, 32'sh7FFF_FFFF, 1'b1,
          '{32'sh0000_0200, 48'sh0, 5'd2}},
        '{CMD_EVAL, 4'd0, 31'h0, 32'sh0, 32'sh8000_0000, 1'b1,
          '{32'shFFFF_FE00, 48'sh0, 5'd2}},
        '{CMD_LOAD, 4'd1, 31'h2000_0000, 32'sh0000_0100, 32'sh0, 1'b0, NO_RESULT},
        '{CMD_EVAL, 4'd0, 31'h0, 32'sh0, 32'sh1800_0000, 1'b1,
          '{32'sh0000_0100, 48'sh0, 5'd1}},
        '{CMD_LOAD, 4'd1, 31'h1000_0000, 32'shFFFF_FF00, 32'sh0, 1'b0, NO_RESULT},
        '{CMD_EVAL, 4'd0, 31'h0, 32'sh0, 32'sh0000_0000, 1'b1,
          '{32'sh0, 48'sh0000_0002_0000, 5'd0}},
        '{CMD_EVAL, 4'd0, 31'h0, 32'sh0, 32'sh1000_0001, 1'b1,
          '{32'shFFFF_FF00, 48'sh0000_0002_0000, 5'd2}},
        '{CMD_LOAD, 4'd0, 31'h0000_0100, 32'sh0000_0000, 32'sh0, 1'b0, NO_RESULT},
        '{CMD_LOAD, 4'd1, 31'h0000_0200, 32'sh8000_0000, 32'sh0, 1'b0, NO_RESULT},
        '{CMD_EVAL, 4'd0, 31'h0, 32'sh0, 32'sh8000_0001, 1'b1,
          '{32'sh7FFF_FFFF, 48'sh0000_0002_0000, 5'd2}},
        '{CMD_EVAL, 4'd0, 31'h0, 32'sh0, 32'sh0000_0180, 1'b1,
          '{32'shC000_0000, 48'sh0000_0002_0000, 5'd1}},
        '{CMD_EVAL, 4'd0, 31'h0, 32'sh0, 32'shFFFF_FE80, 1'b1,
          '{32'sh4000_0000, 48'sh0000_0002_0000, 5'd1}},
        '{CMD_LOAD, 4'd0, 31'h0000_0000, 32'sh8000_0000, 32'sh0, 1'b0, NO_RESULT},
        '{CMD_LOAD, 4'd1, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh0, 1'b0, NO_RESULT},
        '{CMD_EVAL, 4'd0, 31'h0, 32'sh0, 32'sh4000_0000, 1'b0, NO_RESULT},
        '{CMD_EVAL, 4'd0, 31'h0, 32'sh0, 32'sh7FFF_FFFF, 1'b0, NO_RESULT},
        '{CMD_EVAL, 4'd0, 31'h0, 32'sh0, 32'shFFFF_FFFF, 1'b0, NO_RESULT}
    };

    logic                       clk;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic                       cmd = CMD_LOAD;
    logic [PIDX_W-1:0]          point_index = '0;
    logic [STRAIN_W-1:0]        point_strain = '0;
    logic signed [STRESS_W-1:0] point_stress = '0;
    logic signed [X_W-1:0]      strain_in = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [STRESS_W-1:0] stress_out;
    logic signed [TAN_W-1:0]    tangent_out;
    logic [CNT_W-1:0]           segment;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = CFG_POINT_COUNT;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;

    // curve state mirrored from accepted transfers
    logic [STRAIN_W-1:0]        strain_tbl [MAX_POINTS];
    logic signed [STRESS_W-1:0] stress_tbl [MAX_POINTS];
    logic [PC_W-1:0]            point_count_q = POINT_COUNT_RST;
    logic [FS_W-1:0]            floor_shift_q = FLOOR_SHIFT_RST;

    backbone_result_t pending_results [$];
    backbone_result_t head;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int results_checked = 0;
    int loads_sent = 0;
    int evals_sent = 0;
    int hits_below = 0;
    int hits_inside = 0;
    int hits_past = 0;
    int settings_done = 0;

    symmetric_piecewise_linear_backbone dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .point_index  (point_index),
        .point_strain (point_strain),
        .point_stress (point_stress),
        .strain_in    (strain_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .stress_out   (stress_out),
        .tangent_out  (tangent_out),
        .segment      (segment),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("status: fail");
        $finish;
    end

    function automatic longint clip(longint v, longint hi, longint lo);
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function automatic int active_points();
        int n;
        n = point_count_q;
        if (n < 2)
            n = 2;
        if (n > MAX_POINTS)
            n = MAX_POINTS;
        return n;
    endfunction

    // Q20.28 slope between two table points, magnitudes divided and truncated
    function automatic longint slope_between(int a, int b);
        longint d_stress, d_strain;
        longint unsigned num, den, quo;
        bit neg;
        d_stress = longint'(stress_tbl[b]) - longint'(stress_tbl[a]);
        d_strain = longint'(strain_tbl[b]) - longint'(strain_tbl[a]);
        neg = (d_stress < 0) != (d_strain < 0);
        num = (d_stress < 0) ? -d_stress : d_stress;
        num = num << 28;
        den = (d_strain < 0) ? -d_strain : d_strain;
        if (num == 0)
            return 0;
        if (den == 0)
            return (d_stress < 0) ? TAN_LO : TAN_HI;
        quo = num / den;
        if (quo > TAN_HI + 1)
            quo = TAN_HI + 1;
        return clip(neg ? -longint'(quo) : longint'(quo), TAN_HI, TAN_LO);
    endfunction

    function automatic backbone_result_t evaluate_curve(logic signed [X_W-1:0] x_in);
        backbone_result_t r;
        int n, i;
        longint x, mag, sgn, stress, tan, init, fl, d_stress, d_strain, dx, q;
        n = active_points();
        x = x_in;
        sgn = (x > 0) ? 1 : ((x < 0) ? -1 : 0);
        mag = (x < 0) ? -x : x;
        i = 0;
        while (i < n && mag > longint'(strain_tbl[i]))
            i++;
        init = slope_between(0, 1);
        if (i == 0)
        begin
            stress = 0;
            tan = init;
        end
        else if (i == n)
        begin
            stress = longint'(stress_tbl[n-1]) * sgn;
            tan = 0;
        end
        else
        begin
            d_stress = longint'(stress_tbl[i]) - longint'(stress_tbl[i-1]);
            d_strain = longint'(strain_tbl[i]) - longint'(strain_tbl[i-1]);
            dx = mag - longint'(strain_tbl[i-1]);
            q = (dx * ((d_stress < 0) ? -d_stress : d_stress)) / d_strain;
            stress = (longint'(stress_tbl[i-1]) + ((d_stress < 0) ? -q : q)) * sgn;
            tan = slope_between(i - 1, i);
        end
        // flat or falling segments get the floor slope: init shifted right by floor_shift_q, negated if negative
        fl = init >>> floor_shift_q;
        if (tan == 0)
            tan = fl;
        if (tan < 0)
            tan = clip(-fl, TAN_HI, TAN_LO);
        r.stress = clip(stress, S_HI, S_LO);
        r.tangent = tan;
        r.seg = i;
        return r;
    endfunction

    task automatic send_item(input logic op, input logic [PIDX_W-1:0] slot,
                             input logic [STRAIN_W-1:0] strain,
                             input logic signed [STRESS_W-1:0] stress,
                             input logic signed [X_W-1:0] x,
                             input logic known, input backbone_result_t want);
        backbone_result_t r;
        if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99, 0) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        point_index <= slot;
        point_strain <= strain;
        point_stress <= stress;
        strain_in <= x;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (op == CMD_LOAD)
        begin
            strain_tbl[slot] = strain;
            stress_tbl[slot] = stress;
            loads_sent++;
        end
        else
        begin
            r = evaluate_curve(x);
            if (r.seg == 0)
                hits_below++;
            else if (r.seg == active_points())
                hits_past++;
            else
                hits_inside++;
            pending_results.push_back(known ? want : r);
            evals_sent++;
        end
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] pc_data,
                                  input logic [CFG_DATA_W-1:0] fs_data);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_POINT_COUNT;
        cfg_data <= pc_data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        point_count_q = pc_data[PC_W-1:0];
        cfg_index <= CFG_FLOOR_SHIFT;
        cfg_data <= fs_data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        floor_shift_q = fs_data[FS_W-1:0];
        cfg_valid <= 1'b0;
        settings_done++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // full 16-point table: mostly ascending strains, some tight or unordered
    task automatic load_table();
        int layout, fill, k;
        longint s, acc;
        logic signed [STRESS_W-1:0] level;
        layout = $urandom_range(99, 0);
        fill = $urandom_range(99, 0);
        s = 0;
        acc = 0;
        for (k = 0; k < MAX_POINTS; k++)
        begin
            if (layout < 50)
                s = (k == 0) ? $urandom_range(1 << 20, 0) : s + $urandom_range(1 << 26, 1);
            else if (layout < 70)
                s = (k == 0) ? $urandom_range(1 << 30, 0) : s + $urandom_range(3, 0);
            else if (layout < 85)
                s = s + $urandom_range((STRAIN_TOP - s) / (MAX_POINTS - k), 0);
            else
                s = $urandom_range(STRAIN_TOP, 0);
            if (fill < 50)
                level = $urandom;
            else if (fill < 80)
            begin
                acc = acc + longint'($urandom_range(1 << 21, 0)) - (1 << 20);
                level = acc;
            end
            else
            begin
                case ($urandom_range(3, 0))
                    0: level = S32_MIN;
                    1: level = S32_MAX;
                    2: level = 0;
                    default: level = $urandom;
                endcase
            end
            send_item(CMD_LOAD, k[PIDX_W-1:0], s[STRAIN_W-1:0], level, $urandom,
                      1'b0, NO_RESULT);
        end
    endtask

    // strain aimed at segments, point edges and extremes of the current table
    function automatic logic signed [X_W-1:0] pick_strain();
        int n, k, r;
        longint mag, lo, hi;
        n = active_points();
        r = $urandom_range(99, 0);
        if (r < 45)
        begin
            k = $urandom_range(n, 0);
            if (k == n)
                mag = longint'(strain_tbl[n-1]) + longint'($urandom_range(1 << 24, 1));
            else
            begin
                lo = (k == 0) ? -1 : longint'(strain_tbl[k-1]);
                hi = strain_tbl[k];
                mag = (hi > lo) ? lo + 1 + longint'($urandom_range(hi - lo - 1, 0)) : hi;
            end
        end
        else if (r < 65)
        begin
            k = $urandom_range(n - 1, 0);
            mag = longint'(strain_tbl[k]) + longint'($urandom_range(2, 0)) - 1;
        end
        else if (r < 80)
            return $urandom;
        else if (r < 90)
        begin
            case ($urandom_range(4, 0))
                0: return 32'sh0000_0000;
                1: return 32'sh8000_0000;
                2: return 32'sh7FFF_FFFF;
                3: return 32'shFFFF_FFFF;
                default: return 32'sh0000_0001;
            endcase
        end
        else
            mag = $urandom_range(32'h7FFF_FFFF, 0);
        if (mag < 0)
            mag = 0;
        if ($urandom_range(1, 0))
            mag = -mag;
        mag = clip(mag, S_HI, S_LO);
        return mag[X_W-1:0];
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_checked++;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: stress %0d tangent %0d segment %0d",
                                 stress_out, tangent_out, segment);
                end
                else
                begin
                    head = pending_results.pop_front();
                    if (stress_out !== head.stress || tangent_out !== head.tangent ||
                        segment !== head.seg)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: stress %0d/%0d tangent %0d/%0d segment %0d/%0d (expected/actual)",
                                     head.stress, stress_out, head.tangent, tangent_out,
                                     head.seg, segment);
                    end
                end
            end
            out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    initial
    begin
        int k, ph, start, r, slot;
        logic [CFG_DATA_W-1:0] pc_data, fs_data;
        logic [STRAIN_W-1:0] strain;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < 24; k++)
            send_item(PROBES[k].op, PROBES[k].slot, PROBES[k].strain, PROBES[k].stress,
                      PROBES[k].x, PROBES[k].known, PROBES[k].want);
        drain();

        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            pc_data = (ph == PHASES - 1) ? $urandom_range(63, 0) : PC_SET[ph];
            fs_data = (ph == 5 || ph == PHASES - 1) ? $urandom_range(63, 0) : FS_SET[ph];
            apply_settings(pc_data, fs_data);
            start = loads_sent + evals_sent;
            load_table();
            while (loads_sent + evals_sent - start < PHASE_ITEMS)
            begin
                r = $urandom_range(99, 0);
                if (r < 4)
                    load_table();
                else if (r < 10)
                begin
                    slot = $urandom_range(MAX_POINTS - 1, 0);
                    strain = ($urandom_range(99, 0) < 60) ? strain_tbl[slot] : $urandom;
                    send_item(CMD_LOAD, slot[PIDX_W-1:0], strain, $urandom, $urandom,
                              1'b0, NO_RESULT);
                end
                else
                    send_item(CMD_EVAL, $urandom, $urandom, $urandom, pick_strain(),
                              1'b0, NO_RESULT);
            end
            drain();
        end

        $display("covered %0d point loads and %0d evaluations over %0d register settings",
                 loads_sent, evals_sent, settings_done);
        $display("segments: %0d below first point, %0d interpolated, %0d past last; %0d checked",
                 hits_below, hits_inside, hits_past, results_checked);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
